>>> hdl/modexp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modexp_pkg
// Shared widths, control/status types and state codes for the modular
// exponentiation block.
// ----------------------------------------------------------------------------
package modexp_pkg;

    localparam int FIELD_W = 62;
    localparam int WIDTH   = 62;
    localparam int CNT_W   = $clog2(WIDTH);

    // Multiplier unit control and status
    typedef struct packed {
        logic start;
    } t_mul_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_stat;

    // Sequencer states, one-hot
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SQR   = 6'b000010,
        S_SQR_W = 6'b000100,
        S_MUL   = 6'b001000,
        S_MUL_W = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

endpackage

>>> hdl/modexp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modexp_if
// Valid/ready channels for requests and results of the modular
// exponentiation block.
// ----------------------------------------------------------------------------
interface modexp_in_if;
    logic                              valid;
    logic                              ready;
    logic [modexp_pkg::FIELD_W-1:0]    base_value;
    logic [modexp_pkg::FIELD_W-1:0]    exponent_value;
    logic [modexp_pkg::FIELD_W-1:0]    modulus_value;

    modport source (output valid, output base_value, output exponent_value,
                    output modulus_value, input ready);
    modport sink   (input valid, input base_value, input exponent_value,
                    input modulus_value, output ready);
endinterface

interface modexp_out_if;
    logic                              valid;
    logic                              ready;
    logic [modexp_pkg::FIELD_W-1:0]    power_result;

    modport source (output valid, output power_result, input ready);
    modport sink   (input valid, input power_result, output ready);
endinterface

>>> hdl/modexp_mulmod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modexp_mulmod
// Shift-and-add modular multiplier: one bit of y per cycle, LSB first,
// with the accumulator and the doubled addend both reduced each step.
// ----------------------------------------------------------------------------
module modexp_mulmod (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  modexp_pkg::t_mul_ctrl        i_ctrl,
    input  logic [modexp_pkg::WIDTH-1:0] i_x,      // below i_m
    input  logic [modexp_pkg::WIDTH-1:0] i_y,
    input  logic [modexp_pkg::WIDTH-1:0] i_m,
    output modexp_pkg::t_mul_stat        o_stat,
    output logic [modexp_pkg::WIDTH-1:0] o_prod
);

    logic                         r_busy, n_busy;
    logic [modexp_pkg::WIDTH-1:0] r_acc, n_acc;
    logic [modexp_pkg::WIDTH-1:0] r_add, n_add;
    logic [modexp_pkg::WIDTH-1:0] r_y, n_y;
    logic [modexp_pkg::WIDTH-1:0] r_m, n_m;

    logic [modexp_pkg::WIDTH:0]   acc_sum, acc_red;
    logic [modexp_pkg::WIDTH:0]   dbl_sum, dbl_red;
    logic                         y_zero;

    assign y_zero = (r_y == '0);

    always_comb begin
        acc_sum = {1'b0, r_acc} + {1'b0, r_add};
        acc_red = (acc_sum >= {1'b0, r_m}) ? (acc_sum - {1'b0, r_m}) : acc_sum;
        dbl_sum = {r_add, 1'b0};
        dbl_red = (dbl_sum >= {1'b0, r_m}) ? (dbl_sum - {1'b0, r_m}) : dbl_sum;
    end

    always_comb begin
        n_busy = r_busy;
        n_acc  = r_acc;
        n_add  = r_add;
        n_y    = r_y;
        n_m    = r_m;
        if (i_ctrl.start) begin
            n_busy = 1'b1;
            n_acc  = '0;
            n_add  = i_x;
            n_y    = i_y;
            n_m    = i_m;
        end else if (r_busy) begin
            if (y_zero) begin
                n_busy = 1'b0;
            end else begin
                if (r_y[0]) begin
                    n_acc = acc_red[modexp_pkg::WIDTH-1:0];
                end
                n_add = dbl_red[modexp_pkg::WIDTH-1:0];
                n_y   = r_y >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_add <= n_add;
        r_y   <= n_y;
        r_m   <= n_m;
    end

    // Remaining multiplier bits all zero: product is final
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_busy && y_zero;
    assign o_prod      = r_acc;

endmodule

>>> hdl/modular_exponentiation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation
// Computes base^exponent mod modulus by square-and-multiply on a shared
// shift-and-add modular multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries base_value, exponent_value and modulus_value; o_rsp returns
//   power_result, one result per request. A zero exponent gives 1, a zero
//   modulus acts as a modulus of one.
//   i_req.ready is high only while the sequencer is idle; one request is
//   worked at a time.
//   Work: each of the 62 exponent bits, MSB first, costs a squaring and,
//   when the bit is set, a multiply by the base, each product worked on the
//   single multiplier, before the result is loaded into the output register.
//   A zero exponent skips the multiplier. The shared multiplier sets how
//   long a request takes.
//   The result sits in an output register; a new request is taken while it
//   waits. If the receiver stalls when the next result is ready, the
//   sequencer holds in its final state until the register frees.
//   Reset (synchronous, active low) returns to idle and drops o_rsp.valid.
// ----------------------------------------------------------------------------
module modular_exponentiation (
    input  logic            i_clk,
    input  logic            i_rst_n,
    modexp_in_if.sink       i_req,
    modexp_out_if.source    o_rsp
);

    modexp_pkg::t_state             r_state, n_state;
    logic [modexp_pkg::WIDTH-1:0]   r_b, n_b;
    logic [modexp_pkg::WIDTH-1:0]   r_e, n_e;
    logic [modexp_pkg::WIDTH-1:0]   r_m, n_m;
    logic [modexp_pkg::WIDTH-1:0]   r_acc, n_acc;
    logic [modexp_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic                           r_out_valid, n_out_valid;
    logic [modexp_pkg::FIELD_W-1:0] r_out, n_out;

    logic [modexp_pkg::WIDTH-1:0]   in_b, in_e, in_m;
    logic                           req_take;
    logic                           last_bit;

    modexp_pkg::t_mul_ctrl          mul_ctrl;
    modexp_pkg::t_mul_stat          mul_stat;
    logic [modexp_pkg::WIDTH-1:0]   mul_y;
    logic [modexp_pkg::WIDTH-1:0]   mul_prod;

    assign in_b = i_req.base_value[modexp_pkg::WIDTH-1:0];
    assign in_e = i_req.exponent_value[modexp_pkg::WIDTH-1:0];
    assign in_m = i_req.modulus_value[modexp_pkg::WIDTH-1:0];

    assign i_req.ready = (r_state == modexp_pkg::S_IDLE);
    assign req_take    = i_req.valid && (r_state == modexp_pkg::S_IDLE);
    assign last_bit    = (r_cnt == modexp_pkg::CNT_W'(modexp_pkg::WIDTH - 1));

    assign mul_ctrl.start = (r_state == modexp_pkg::S_SQR) ||
                            (r_state == modexp_pkg::S_MUL);
    assign mul_y = (r_state == modexp_pkg::S_SQR) ? r_acc : r_b;

    modexp_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (mul_ctrl),
        .i_x     (r_acc),
        .i_y     (mul_y),
        .i_m     (r_m),
        .o_stat  (mul_stat),
        .o_prod  (mul_prod)
    );

    always_comb begin
        n_state     = r_state;
        n_b         = r_b;
        n_e         = r_e;
        n_m         = r_m;
        n_acc       = r_acc;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (o_rsp.valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            modexp_pkg::S_IDLE: begin
                if (req_take) begin
                    n_b   = in_b;
                    n_e   = in_e;
                    n_cnt = '0;
                    // Zero modulus acts as one
                    n_m   = (in_m == '0) ? modexp_pkg::WIDTH'(1) : in_m;
                    if (in_e == '0) begin
                        n_acc   = modexp_pkg::WIDTH'(1);
                        n_state = modexp_pkg::S_DONE;
                    end else begin
                        // Running value starts at 1 mod m
                        n_acc   = (in_m > modexp_pkg::WIDTH'(1)) ?
                                  modexp_pkg::WIDTH'(1) : '0;
                        n_state = modexp_pkg::S_SQR;
                    end
                end
            end
            modexp_pkg::S_SQR: begin
                n_state = modexp_pkg::S_SQR_W;
            end
            modexp_pkg::S_SQR_W: begin
                if (mul_stat.done) begin
                    n_acc = mul_prod;
                    if (r_e[modexp_pkg::WIDTH-1]) begin
                        n_state = modexp_pkg::S_MUL;
                    end else begin
                        n_e   = r_e << 1;
                        n_cnt = r_cnt + 1'b1;
                        n_state = last_bit ? modexp_pkg::S_DONE : modexp_pkg::S_SQR;
                    end
                end
            end
            modexp_pkg::S_MUL: begin
                n_state = modexp_pkg::S_MUL_W;
            end
            modexp_pkg::S_MUL_W: begin
                if (mul_stat.done) begin
                    n_acc = mul_prod;
                    n_e   = r_e << 1;
                    n_cnt = r_cnt + 1'b1;
                    n_state = last_bit ? modexp_pkg::S_DONE : modexp_pkg::S_SQR;
                end
            end
            modexp_pkg::S_DONE: begin
                // Hold until the output register is free
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out       = modexp_pkg::FIELD_W'(r_acc);
                    n_state     = modexp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = modexp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= modexp_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b   <= n_b;
        r_e   <= n_e;
        r_m   <= n_m;
        r_acc <= n_acc;
        r_out <= n_out;
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.power_result = r_out;

endmodule
